/* hw/rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants and types for the relative path normalizer.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // path characters
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // verdict codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_ABSOLUTE = 3'd2;
  localparam logic [2:0] ST_BADCHAR  = 3'd3;
  localparam logic [2:0] ST_EMPTYSEG = 3'd4;
  localparam logic [2:0] ST_DOTDOT   = 3'd5;
  localparam logic [2:0] ST_HIDDEN   = 3'd6;

  // results caused by one item, handed from the core to the emitter
  typedef struct packed {
    logic       load;       // core hands over an item this cycle
    logic       emit_sep;   // a joining slash comes first
    logic       emit_ch;    // the path byte itself
    logic [7:0] ch;
    logic       emit_ver;   // verdict closes the path
    logic [2:0] status;
  } group_t;

endpackage

/* hw/rtl/rpn_core.sv */
// ----------------------------------------------------------------------------
// rpn_core
// Input register and per-path segment tracker; works out the results of one
// item in a single pass.
// ----------------------------------------------------------------------------
module rpn_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tuser,
  input  logic          s_tlast,
  input  logic          grp_free,
  output rpn_pkg::group_t grp
);

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_DOT    = 3'd1;
  localparam logic [2:0] PH_DOTDOT = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  // input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_has;
  logic       in_last;

  // path state
  logic       seen_any, seen_any_next;
  logic       abs_flag, abs_flag_next;
  logic       bad_flag, bad_flag_next;
  logic [2:0] seg_err, seg_err_next;
  logic [2:0] phase, phase_next;
  logic       emitted, emitted_next;

  logic       advance;
  logic       emit_sep;
  logic       emit_ch;
  logic       is_slash;
  logic       is_dot;
  logic [2:0] note_code;
  logic       note;
  logic [2:0] verdict;

  assign advance  = in_valid && grp_free;
  assign s_tready = !in_valid || grp_free;
  assign is_slash = (in_ch == rpn_pkg::CH_SLASH);
  assign is_dot   = (in_ch == rpn_pkg::CH_DOT);

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch   <= s_tdata;
      in_has  <= s_tuser;
      in_last <= s_tlast;
    end
  end

  // segment phase and error tracking
  always_comb begin
    seen_any_next = seen_any;
    abs_flag_next = abs_flag;
    bad_flag_next = bad_flag;
    phase_next    = phase;
    emitted_next  = emitted;
    emit_sep      = 1'b0;
    emit_ch       = 1'b0;
    note          = 1'b0;
    note_code     = rpn_pkg::ST_OK;

    if (in_has) begin
      if (!seen_any && (is_slash || in_ch == rpn_pkg::CH_BSLASH)) begin
        abs_flag_next = 1'b1;
      end
      seen_any_next = 1'b1;
      if (in_ch == rpn_pkg::CH_BSLASH || in_ch == rpn_pkg::CH_NUL) begin
        bad_flag_next = 1'b1;
      end
      unique case (phase)
        PH_START: begin
          if (is_slash) begin
            note      = 1'b1;
            note_code = rpn_pkg::ST_EMPTYSEG;
          end else if (is_dot) begin
            phase_next = PH_DOT;
          end else begin
            emit_sep     = emitted;
            emit_ch      = 1'b1;
            emitted_next = 1'b1;
            phase_next   = PH_BODY;
          end
        end
        PH_DOT: begin
          if (is_slash) begin
            phase_next = PH_START;
          end else if (is_dot) begin
            phase_next = PH_DOTDOT;
          end else begin
            note       = 1'b1;
            note_code  = rpn_pkg::ST_HIDDEN;
            phase_next = PH_SKIP;
          end
        end
        PH_DOTDOT: begin
          note = 1'b1;
          if (is_slash) begin
            note_code  = rpn_pkg::ST_DOTDOT;
            phase_next = PH_START;
          end else begin
            note_code  = rpn_pkg::ST_HIDDEN;
            phase_next = PH_SKIP;
          end
        end
        PH_BODY: begin
          if (is_slash) begin
            phase_next = PH_START;
          end else begin
            emit_ch = 1'b1;
          end
        end
        default: begin
          if (is_slash) begin
            phase_next = PH_START;
          end
        end
      endcase
    end

    // path ending on a bare ".." segment
    if (in_last && phase_next == PH_DOTDOT) begin
      note      = 1'b1;
      note_code = rpn_pkg::ST_DOTDOT;
    end

    seg_err_next = (note && seg_err == rpn_pkg::ST_OK) ? note_code : seg_err;
  end

  // verdict by priority
  always_comb begin
    priority if (!seen_any_next) begin
      verdict = rpn_pkg::ST_EMPTY;
    end else if (abs_flag_next) begin
      verdict = rpn_pkg::ST_ABSOLUTE;
    end else if (bad_flag_next) begin
      verdict = rpn_pkg::ST_BADCHAR;
    end else if (seg_err_next != rpn_pkg::ST_OK) begin
      verdict = seg_err_next;
    end else if (!emitted_next) begin
      verdict = rpn_pkg::ST_EMPTY;
    end else begin
      verdict = rpn_pkg::ST_OK;
    end
  end

  // results handed to the emitter, bytes suppressed once an error is known
  always_comb begin
    grp.load     = advance;
    grp.emit_ch  = emit_ch && !(abs_flag_next || bad_flag_next ||
                                seg_err_next != rpn_pkg::ST_OK);
    grp.emit_sep = emit_sep && grp.emit_ch;
    grp.ch       = in_ch;
    grp.emit_ver = in_last;
    grp.status   = verdict;
  end

  // state update, back to reset after the final item of a path
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any <= 1'b0;
      abs_flag <= 1'b0;
      bad_flag <= 1'b0;
      seg_err  <= rpn_pkg::ST_OK;
      phase    <= PH_START;
      emitted  <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        seen_any <= 1'b0;
        abs_flag <= 1'b0;
        bad_flag <= 1'b0;
        seg_err  <= rpn_pkg::ST_OK;
        phase    <= PH_START;
        emitted  <= 1'b0;
      end else begin
        seen_any <= seen_any_next;
        abs_flag <= abs_flag_next;
        bad_flag <= bad_flag_next;
        seg_err  <= seg_err_next;
        phase    <= phase_next;
        emitted  <= emitted_next;
      end
    end
  end

endmodule

/* hw/rtl/rpn_emit.sv */
// ----------------------------------------------------------------------------
// rpn_emit
// Result register: holds the up to three results of one item and sends
// them out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module rpn_emit (
  input  logic            clk,
  input  logic            rst,
  input  rpn_pkg::group_t grp,
  output logic            grp_free,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic            m_tuser,
  output logic            m_tlast
);

  logic       sep_pend, sep_pend_next;
  logic       ch_pend, ch_pend_next;
  logic       ver_pend, ver_pend_next;
  logic [7:0] ch;
  logic [2:0] status;
  logic       take;
  logic       one_left;
  logic [7:0] cur_byte;
  logic [2:0] cur_status;

  assign m_tvalid = sep_pend || ch_pend || ver_pend;
  assign take     = m_tvalid && m_tready;
  assign one_left = (sep_pend ^ ch_pend ^ ver_pend) &&
                    !(sep_pend && ch_pend && ver_pend);
  assign grp_free = !m_tvalid || (one_left && m_tready);

  // next pending set: drop the front result, or take a new group
  always_comb begin
    sep_pend_next = sep_pend;
    ch_pend_next  = ch_pend;
    ver_pend_next = ver_pend;
    if (take) begin
      priority if (sep_pend) begin
        sep_pend_next = 1'b0;
      end else if (ch_pend) begin
        ch_pend_next = 1'b0;
      end else begin
        ver_pend_next = 1'b0;
      end
    end
    if (grp.load) begin
      sep_pend_next = grp.emit_sep;
      ch_pend_next  = grp.emit_ch;
      ver_pend_next = grp.emit_ver;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_pend <= 1'b0;
      ch_pend  <= 1'b0;
      ver_pend <= 1'b0;
    end else begin
      sep_pend <= sep_pend_next;
      ch_pend  <= ch_pend_next;
      ver_pend <= ver_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (grp.load) begin
      ch     <= grp.ch;
      status <= grp.status;
    end
  end

  // front result selection
  always_comb begin
    priority if (sep_pend) begin
      cur_byte   = rpn_pkg::CH_SLASH;
      cur_status = rpn_pkg::ST_OK;
      m_tuser    = 1'b0;
      m_tlast    = !ch_pend && !ver_pend;
    end else if (ch_pend) begin
      cur_byte   = ch;
      cur_status = rpn_pkg::ST_OK;
      m_tuser    = 1'b0;
      m_tlast    = !ver_pend;
    end else begin
      cur_byte   = 8'h00;
      cur_status = status;
      m_tuser    = 1'b1;
      m_tlast    = 1'b1;
    end
  end

  assign m_tdata = {5'b0, cur_status, cur_byte};

endmodule

/* hw/rtl/relative_path_normalizer.sv */
// ----------------------------------------------------------------------------
// relative_path_normalizer
// Streams a relative path byte by byte, drops "." segments, joins kept
// segments with one slash and closes each path with a verdict.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                      | tuser      | tlast
//  s_      | in        | [7:0] ch                   | has_char   | last
//  m_      | out       | [7:0] out_byte, [10:8] st  | is_verdict | last_of_run
//
// an item passes through the input register, then the result register;
// items with a single result go through at one per cycle while m_tready
// is high; an item that causes a joining slash, or a byte plus verdict,
// holds the result register until its results are out, and input waits
// rst clears the input register, the path state and all pending results
// either side may stall at any time; results are never lost or repeated
// ----------------------------------------------------------------------------
module relative_path_normalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] ch
  input  logic        s_tuser,  // [0] has_char
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_tuser,  // [0] is_verdict
  output logic        m_tlast
);

  rpn_pkg::group_t grp;
  logic            grp_free;

  // segment tracker and result generation
  rpn_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .grp_free (grp_free),
    .grp      (grp)
  );

  // result register and serializer
  rpn_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .grp      (grp),
    .grp_free (grp_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/rpn_result_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_result_check
// Watches both stream channels of the path normalizer, works out the bytes
// and verdicts each accepted item should cause, and compares every returned
// result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rpn_result_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] ch
  input  logic        s_tuser,  // [0] has_char
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  input  logic        m_tuser,  // [0] is_verdict
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [2:0] {
    SEG_START,
    SEG_DOT,
    SEG_DOTDOT,
    SEG_BODY,
    SEG_SKIP
  } seg_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_verdict;
    logic [2:0] status;
    logic       last_of_run;
  } path_result_t;

  path_result_t expected_q[$];
  int           failures = 0;

  // per-path tracking state
  logic         seen_any;
  logic         absolute_flag;
  logic         bad_char_flag;
  logic         kept_segment;
  logic [2:0]   seg_error;
  seg_phase_t   phase;

  assign fail_count = failures;

  task automatic clear_path();
    seen_any      = 1'b0;
    absolute_flag = 1'b0;
    bad_char_flag = 1'b0;
    kept_segment  = 1'b0;
    seg_error     = rpn_pkg::ST_OK;
    phase         = SEG_START;
  endtask

  // only the first bad segment of a path counts
  task automatic note_segment_error(input logic [2:0] code);
    if (seg_error == rpn_pkg::ST_OK) begin
      seg_error = code;
    end
  endtask

  // expected results of one accepted item, appended in order
  task automatic normalize_item(input logic [7:0] c, input logic has_char, input logic fin);
    path_result_t res[$];
    logic         emit_sep;
    logic         emit_ch;
    logic [2:0]   verdict;
    emit_sep = 1'b0;
    emit_ch  = 1'b0;
    if (has_char) begin
      if (!seen_any && (c == rpn_pkg::CH_SLASH || c == rpn_pkg::CH_BSLASH)) begin
        absolute_flag = 1'b1;
      end
      seen_any = 1'b1;
      if (c == rpn_pkg::CH_BSLASH || c == rpn_pkg::CH_NUL) begin
        bad_char_flag = 1'b1;
      end
      case (phase)
        SEG_START: begin
          if (c == rpn_pkg::CH_SLASH) begin
            note_segment_error(rpn_pkg::ST_EMPTYSEG);
          end else if (c == rpn_pkg::CH_DOT) begin
            phase = SEG_DOT;
          end else begin
            emit_sep     = kept_segment;
            emit_ch      = 1'b1;
            kept_segment = 1'b1;
            phase        = SEG_BODY;
          end
        end
        SEG_DOT: begin
          if (c == rpn_pkg::CH_SLASH) begin
            phase = SEG_START;
          end else if (c == rpn_pkg::CH_DOT) begin
            phase = SEG_DOTDOT;
          end else begin
            note_segment_error(rpn_pkg::ST_HIDDEN);
            phase = SEG_SKIP;
          end
        end
        SEG_DOTDOT: begin
          if (c == rpn_pkg::CH_SLASH) begin
            note_segment_error(rpn_pkg::ST_DOTDOT);
            phase = SEG_START;
          end else begin
            note_segment_error(rpn_pkg::ST_HIDDEN);
            phase = SEG_SKIP;
          end
        end
        SEG_BODY: begin
          if (c == rpn_pkg::CH_SLASH) begin
            phase = SEG_START;
          end else begin
            emit_ch = 1'b1;
          end
        end
        default: begin
          if (c == rpn_pkg::CH_SLASH) begin
            phase = SEG_START;
          end
        end
      endcase
      // bytes stop once any error is known for the path
      if (emit_ch && !absolute_flag && !bad_char_flag && seg_error == rpn_pkg::ST_OK) begin
        if (emit_sep) begin
          res.insert(res.size(),
                     path_result_t'{rpn_pkg::CH_SLASH, 1'b0, rpn_pkg::ST_OK, 1'b0});
        end
        res.insert(res.size(), path_result_t'{c, 1'b0, rpn_pkg::ST_OK, 1'b0});
      end
    end
    if (fin) begin
      if (phase == SEG_DOTDOT) begin
        note_segment_error(rpn_pkg::ST_DOTDOT);
      end
      if (!seen_any) begin
        verdict = rpn_pkg::ST_EMPTY;
      end else if (absolute_flag) begin
        verdict = rpn_pkg::ST_ABSOLUTE;
      end else if (bad_char_flag) begin
        verdict = rpn_pkg::ST_BADCHAR;
      end else if (seg_error != rpn_pkg::ST_OK) begin
        verdict = seg_error;
      end else if (!kept_segment) begin
        verdict = rpn_pkg::ST_EMPTY;
      end else begin
        verdict = rpn_pkg::ST_OK;
      end
      res.insert(res.size(), path_result_t'{8'h00, 1'b1, verdict, 1'b0});
      clear_path();
    end
    if (res.size() > 0) begin
      res[res.size() - 1].last_of_run = 1'b1;
    end
    foreach (res[i]) begin
      expected_q.insert(expected_q.size(), res[i]);
    end
  endtask

  task automatic log_failure(input string what, input path_result_t want,
                             input path_result_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t %s: expected byte %02h verdict %b status %0d last %b",
               $realtime, what, want.out_byte, want.is_verdict, want.status,
               want.last_of_run);
      $display("%0t %s: got      byte %02h verdict %b status %0d last %b",
               $realtime, what, got.out_byte, got.is_verdict, got.status,
               got.last_of_run);
    end
  endtask

  task automatic check_result();
    path_result_t got;
    path_result_t want;
    got = '{m_tdata[7:0], m_tuser, m_tdata[10:8], m_tlast};
    if (expected_q.size() == 0) begin
      log_failure("result with nothing pending", '0, got);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        log_failure("result mismatch", want, got);
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_path();
      expected_q.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        normalize_item(s_tdata, s_tuser, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives path strings into the relative path normalizer: a directed set of
// corner paths, then random well-formed paths with injected faults, under
// random stalls on both sides. The result checker flags any mismatch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TARGET_ITEMS = 220;
  localparam int HOLD_AT      = 90;
  localparam int QUIET_AT     = 180;
  localparam int LONG_HOLD    = 300;

  typedef enum int {
    FAULT_NONE,
    FAULT_ABSOLUTE,
    FAULT_BADCHAR,
    FAULT_EXTRA_SLASH,
    FAULT_PARENT,
    FAULT_HIDDEN,
    FAULT_NOTHING_KEPT
  } path_fault_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] ch
  logic        s_tuser;   // [0] has_char
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] out_byte, [10:8] status, [15:11] zero
  logic        m_tuser;   // [0] is_verdict
  logic        m_tlast;

  int          fail_count;
  int          pending;
  int          items_sent = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  logic [7:0]  path_bytes[$];

  always #4 clk = ~clk;

  relative_path_normalizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  rpn_result_check result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // offer one item and wait for its handshake
  task automatic send_item(input logic [7:0] c, input logic has_char, input logic fin);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= has_char;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    if (has_char || fin) begin
      items_sent++;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] name_char();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return 8'($urandom_range(0, 255));
    end else if (pick == 1) begin
      return rpn_pkg::CH_DOT;
    end
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // build a random relative path, sometimes with one fault mixed in
  task automatic make_path();
    int          nseg;
    int          s;
    int          pos;
    path_fault_t fault;
    path_bytes.delete();
    nseg  = $urandom_range(1, 3);
    fault = FAULT_NONE;
    if ($urandom_range(0, 9) < 3) begin
      fault = path_fault_t'($urandom_range(FAULT_ABSOLUTE, FAULT_NOTHING_KEPT));
    end
    for (s = 0; s < nseg; s++) begin
      if (s > 0) begin
        path_bytes.insert(path_bytes.size(), rpn_pkg::CH_SLASH);
      end
      if ($urandom_range(0, 7) == 0) begin
        path_bytes.insert(path_bytes.size(), rpn_pkg::CH_DOT);  // current-dir segment, dropped
      end else begin
        path_bytes.insert(path_bytes.size(), 8'($urandom_range(8'h61, 8'h7A)));
        repeat ($urandom_range(0, 3)) path_bytes.insert(path_bytes.size(), name_char());
      end
    end
    pos = $urandom_range(0, path_bytes.size());
    case (fault)
      FAULT_ABSOLUTE: begin
        path_bytes.push_front($urandom_range(0, 1) ? rpn_pkg::CH_SLASH : rpn_pkg::CH_BSLASH);
      end
      FAULT_BADCHAR: begin
        path_bytes.insert(pos, $urandom_range(0, 1) ? rpn_pkg::CH_NUL : rpn_pkg::CH_BSLASH);
      end
      FAULT_EXTRA_SLASH: begin
        path_bytes.insert(pos, rpn_pkg::CH_SLASH);
      end
      FAULT_PARENT: begin
        path_bytes.insert(path_bytes.size(), rpn_pkg::CH_SLASH);
        path_bytes.insert(path_bytes.size(), rpn_pkg::CH_DOT);
        path_bytes.insert(path_bytes.size(), rpn_pkg::CH_DOT);
      end
      FAULT_HIDDEN: begin
        // ".x/" or "..x/" in front
        path_bytes.push_front(rpn_pkg::CH_SLASH);
        path_bytes.push_front(8'($urandom_range(8'h61, 8'h7A)));
        path_bytes.push_front(rpn_pkg::CH_DOT);
        if ($urandom_range(0, 1) == 0) begin
          path_bytes.push_front(rpn_pkg::CH_DOT);
        end
      end
      FAULT_NOTHING_KEPT: begin
        path_bytes.delete();
        path_bytes.insert(0, rpn_pkg::CH_DOT);
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 4) == 0) begin
      path_bytes.insert(path_bytes.size(), rpn_pkg::CH_SLASH);  // trailing slash
    end
  endtask

  // send the built path, closed on its last byte or by an end-only item
  task automatic send_path(input bit end_marker);
    int i;
    for (i = 0; i < path_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);  // ignored filler
      end
      send_item(path_bytes[i], 1'b1, !end_marker && i == path_bytes.size() - 1);
    end
    if (end_marker || path_bytes.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corner paths
    send_item(8'hA5, 1'b0, 1'b1);               // empty path
    send_item(8'h61, 1'b1, 1'b0);               // "a/./" then 0xff: joined with one slash
    send_item(rpn_pkg::CH_SLASH, 1'b1, 1'b0);
    send_item(rpn_pkg::CH_DOT, 1'b1, 1'b0);
    send_item(rpn_pkg::CH_SLASH, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(rpn_pkg::CH_SLASH, 1'b1, 1'b1);   // leading slash
    send_item(rpn_pkg::CH_BSLASH, 1'b1, 1'b1);  // leading backslash
    send_item(8'h62, 1'b1, 1'b0);               // nul byte
    send_item(rpn_pkg::CH_NUL, 1'b1, 1'b1);
    send_item(8'h63, 1'b1, 1'b0);               // "c//d" with an ignored item inside
    send_item(rpn_pkg::CH_SLASH, 1'b1, 1'b0);
    send_item(rpn_pkg::CH_SLASH, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h64, 1'b1, 1'b1);
    send_item(rpn_pkg::CH_DOT, 1'b1, 1'b0);     // ".." at the end
    send_item(rpn_pkg::CH_DOT, 1'b1, 1'b1);
    send_item(rpn_pkg::CH_DOT, 1'b1, 1'b0);     // hidden segment
    send_item(8'h68, 1'b1, 1'b1);
    send_item(rpn_pkg::CH_DOT, 1'b1, 1'b0);     // "." only, closed by an end-only item
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h78, 1'b1, 1'b0);               // "x/" trailing slash
    send_item(rpn_pkg::CH_SLASH, 1'b1, 1'b1);
    wait_drained();

    // random paths
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= HOLD_AT) begin
        hold_req = 1'b1;
      end
      if (items_sent >= QUIET_AT) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      make_path();
      send_path($urandom_range(0, 4) == 0);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
